>>> rtl/core/ssfe_pkg.sv
package ssfe_pkg;

  localparam int unsigned MAX_BYTES = 8;

  localparam logic [1:0] OP_EXCHANGE = 2'd0;
  localparam logic [1:0] OP_LOAD     = 2'd1;
  localparam logic [1:0] OP_POLL     = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic [63:0] response_word;
  } ssfe_in_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        frame_valid;
    logic [63:0] frame_data;
    logic        response_pending;
  } ssfe_out_t;

endpackage

>>> rtl/core/spi_slave_frame_exchange_unit.sv
// Channel  Direction  Handshake           Beat
// in_      input      in_valid/in_ready   ssfe_in_t (operation, rx_byte, response_word)
// out_     output     out_valid/out_ready ssfe_out_t (tx_byte, frame_valid, frame_data,
//                                          response_pending)
//
// State is updated and the result is registered into out_, or into the buffer entry while
// out_ is stalled, when a beat is accepted. Rate is one beat per cycle while the buffer has
// room, set by the single state update path in front of the result register; a two-entry
// output buffer keeps in_ready high while one result waits.
// Reset is synchronous on rst_n and clears all frame state and both output entries.
module spi_slave_frame_exchange_unit #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssfe_pkg::ssfe_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssfe_pkg::ssfe_out_t out_data
);
  import ssfe_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam int unsigned RSP_IDX_W = $clog2(MAX_BYTES);

  logic [7:0]       req_bytes_r [FRAME_BYTES];
  logic [7:0]       req_bytes_nxt [FRAME_BYTES];
  logic [CNT_W-1:0] req_cnt_r, req_cnt_nxt;
  logic             collecting_r, collecting_nxt;
  logic [7:0]       rsp_bytes_r [MAX_BYTES];
  logic [7:0]       rsp_bytes_nxt [MAX_BYTES];
  logic [POS_W-1:0] rsp_pos_r, rsp_pos_nxt;

  ssfe_out_t out_r, skid_r, res;
  logic      out_valid_r, skid_valid_r;
  logic      push, pop;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;

  always_comb begin
    logic [CNT_W-1:0] cnt_tmp;
    logic             coll_tmp;
    req_bytes_nxt  = req_bytes_r;
    rsp_bytes_nxt  = rsp_bytes_r;
    req_cnt_nxt    = req_cnt_r;
    collecting_nxt = collecting_r;
    rsp_pos_nxt    = rsp_pos_r;
    res            = '0;
    cnt_tmp        = req_cnt_r;
    coll_tmp       = collecting_r;
    case (in_data.operation)
      OP_EXCHANGE: begin
        if (rsp_bytes_r[0] != 8'd0) begin
          res.tx_byte = rsp_bytes_r[RSP_IDX_W'(rsp_pos_r)];
          if (rsp_pos_r == POS_W'(FRAME_BYTES - 1)) begin
            rsp_pos_nxt      = '0;
            cnt_tmp          = '0;
            rsp_bytes_nxt[0] = 8'd0;
          end else begin
            rsp_pos_nxt = rsp_pos_r + 1'b1;
          end
        end
        if (in_data.rx_byte != 8'd0) begin
          coll_tmp = 1'b1;
        end
        if (coll_tmp && (cnt_tmp < CNT_W'(FRAME_BYTES))) begin
          for (int i = 0; i < FRAME_BYTES; i++) begin
            if (cnt_tmp == CNT_W'(i)) begin
              req_bytes_nxt[i] = in_data.rx_byte;
            end
          end
          cnt_tmp = cnt_tmp + 1'b1;
        end
        if (cnt_tmp == CNT_W'(FRAME_BYTES)) begin
          coll_tmp = 1'b0;
        end
        req_cnt_nxt    = cnt_tmp;
        collecting_nxt = coll_tmp;
      end
      OP_LOAD: begin
        for (int i = 0; i < MAX_BYTES; i++) begin
          rsp_bytes_nxt[i] = in_data.response_word[8*i +: 8];
        end
      end
      OP_POLL: begin
        if ((rsp_bytes_r[0] == 8'd0) && (req_cnt_r == CNT_W'(FRAME_BYTES))) begin
          res.frame_valid = 1'b1;
          for (int i = 0; i < FRAME_BYTES; i++) begin
            res.frame_data[8*i +: 8] = req_bytes_r[i];
          end
        end
      end
      default: begin
      end
    endcase
    res.response_pending = (rsp_bytes_nxt[0] != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r    <= '0;
      collecting_r <= 1'b0;
      rsp_pos_r    <= '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
        rsp_bytes_r[i] <= 8'd0;
      end
    end else if (push) begin
      req_cnt_r    <= req_cnt_nxt;
      collecting_r <= collecting_nxt;
      rsp_pos_r    <= rsp_pos_nxt;
      rsp_bytes_r  <= rsp_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        req_bytes_r[i] <= 8'd0;
      end
    end else if (push) begin
      req_bytes_r <= req_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    req_cnt_r <= CNT_W'(FRAME_BYTES))
    else $error("request count beyond frame length");

  a_collect_room: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (req_cnt_r < CNT_W'(FRAME_BYTES)))
    else $error("collecting with a full request");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("buffered beat without an output beat");

  a_frame_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_valid) |-> !out_r.response_pending)
    else $error("frame reported while a response is pending");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_valid_r) |=> out_valid_r)
    else $error("accepted beat did not reach the output");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssfe_pkg::*;

  localparam int FRAME_LEN = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ssfe_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ssfe_out_t out_data;

  ssfe_in_t  link_beats[$];
  ssfe_out_t slave_replies[$];
  ssfe_out_t awaited_reply;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_phase = 1'b0;
  int hold_count = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  logic [7:0] req_bytes [FRAME_LEN];
  logic [3:0] req_count;
  logic       collecting;
  logic [7:0] rsp_bytes [8];
  logic [2:0] rsp_pos;

  spi_slave_frame_exchange_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ssfe_out_t compute_slave_reply(ssfe_in_t beat);
    ssfe_out_t reply;
    int i;
    reply = '0;
    case (beat.operation)
      OP_EXCHANGE: begin
        if (rsp_bytes[0] != 8'd0) begin
          reply.tx_byte = rsp_bytes[rsp_pos];
          if (int'(rsp_pos) + 1 >= FRAME_LEN) begin
            rsp_pos = 3'd0;
            req_count = 4'd0;
            rsp_bytes[0] = 8'd0;
          end else begin
            rsp_pos = rsp_pos + 3'd1;
          end
        end
        if (!collecting && beat.rx_byte != 8'd0) begin
          collecting = 1'b1;
        end
        if (collecting && req_count < FRAME_LEN) begin
          req_bytes[req_count[2:0]] = beat.rx_byte;
          req_count = req_count + 4'd1;
        end
        if (req_count == FRAME_LEN) begin
          collecting = 1'b0;
        end
      end
      OP_LOAD: begin
        for (i = 0; i < 8; i++) begin
          rsp_bytes[i] = beat.response_word[8*i +: 8];
        end
      end
      OP_POLL: begin
        if (rsp_bytes[0] == 8'd0 && req_count == FRAME_LEN) begin
          reply.frame_valid = 1'b1;
          for (i = 0; i < FRAME_LEN; i++) begin
            reply.frame_data[8*i +: 8] = req_bytes[i];
          end
        end
      end
      default: begin
      end
    endcase
    reply.response_pending = (rsp_bytes[0] != 8'd0);
    return reply;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      req_count = 4'd0;
      collecting = 1'b0;
      rsp_pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
        req_bytes[i] = 8'd0;
        rsp_bytes[i] = 8'd0;
      end
    end else begin
      if (in_valid && in_ready) begin
        slave_replies.push_back(compute_slave_reply(in_data));
      end
      if (!in_valid || in_ready) begin
        if (link_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= link_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (slave_replies.size() == 0) begin
          $error("Result beat %0h arrived with nothing outstanding.", out_data);
          mismatches++;
        end else begin
          awaited_reply = slave_replies.pop_front();
          compare_field("tx_byte", awaited_reply.tx_byte, out_data.tx_byte);
          compare_field("frame_valid", awaited_reply.frame_valid, out_data.frame_valid);
          compare_field("frame_data", awaited_reply.frame_data, out_data.frame_data);
          compare_field("response_pending", awaited_reply.response_pending,
                        out_data.response_pending);
        end
      end
      if (hold_phase && hold_count < HOLD_CYCLES) begin
        hold_count <= hold_count + 1;
        out_ready <= 1'b0;
      end else begin
        if (!hold_phase) begin
          hold_count <= 0;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("spi_slave_frame_exchange_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(logic [1:0] op, logic [7:0] rx, logic [63:0] word);
    ssfe_in_t beat;
    beat.operation = op;
    beat.rx_byte = rx;
    beat.response_word = word;
    link_beats.push_back(beat);
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(3) == 0) begin
      return 8'd0;
    end
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_frame_traffic();
    logic [63:0] word;
    int extra;
    if ($urandom_range(1) == 1) begin
      word = rand_word();
      if ($urandom_range(7) == 0) begin
        word[7:0] = 8'd0;
      end
      push_beat(OP_LOAD, rand_byte(), word);
    end
    repeat ($urandom_range(2)) push_beat(OP_EXCHANGE, 8'd0, rand_word());
    push_beat(OP_EXCHANGE, 8'($urandom_range(1, 255)), rand_word());
    extra = 7 + $urandom_range(3);
    repeat (extra) push_beat(OP_EXCHANGE, rand_byte(), rand_word());
    repeat (1 + $urandom_range(1)) push_beat(OP_POLL, rand_byte(), rand_word());
  endtask

  task automatic queue_response_readout();
    logic [63:0] word;
    word = rand_word();
    if (word[7:0] == 8'd0) begin
      word[7:0] = 8'h01;
    end
    push_beat(OP_LOAD, rand_byte(), word);
    push_beat(OP_POLL, rand_byte(), rand_word());
    repeat (FRAME_LEN) push_beat(OP_EXCHANGE, ($urandom_range(3) == 0) ? rand_byte() : 8'd0,
                                 rand_word());
    push_beat(OP_POLL, rand_byte(), rand_word());
  endtask

  task automatic queue_noise();
    repeat (1 + $urandom_range(5)) push_beat(2'($urandom_range(3)), 8'($urandom), rand_word());
  endtask

  task automatic wait_drained();
    while (link_beats.size() != 0 || in_valid || slave_replies.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int idle_pct, int ready_stall_pct, int n_beats);
    @(negedge clk);
    send_idle_pct = idle_pct;
    stall_pct = ready_stall_pct;
    while (link_beats.size() < n_beats) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: queue_frame_traffic();
        5, 6:          queue_response_readout();
        default:       queue_noise();
      endcase
    end
    wait_drained();
  endtask

  task automatic queue_directed();
    push_beat(OP_POLL, 8'h00, 64'h0);
    push_beat(OP_UNUSED, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_beat(OP_EXCHANGE, 8'hFF, 64'h0);
    push_beat(OP_EXCHANGE, 8'h00, 64'h0);
    push_beat(OP_EXCHANGE, 8'h80, 64'h0);
    push_beat(OP_EXCHANGE, 8'h01, 64'h0);
    push_beat(OP_EXCHANGE, 8'h7F, 64'h0);
    push_beat(OP_EXCHANGE, 8'hAA, 64'h0);
    push_beat(OP_EXCHANGE, 8'h55, 64'h0);
    push_beat(OP_EXCHANGE, 8'hFE, 64'h0);
    push_beat(OP_POLL, 8'h00, 64'h0);
    push_beat(OP_POLL, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_beat(OP_EXCHANGE, 8'h33, 64'h0);
    push_beat(OP_LOAD, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    push_beat(OP_EXCHANGE, 8'h00, 64'h0);
    push_beat(OP_EXCHANGE, 8'h00, 64'h0);
    push_beat(OP_LOAD, 8'h00, 64'h0123_4567_89AB_CDEF);
    push_beat(OP_EXCHANGE, 8'h12, 64'h0);
    push_beat(OP_EXCHANGE, 8'h00, 64'h0);
    push_beat(OP_EXCHANGE, 8'h34, 64'h0);
    push_beat(OP_EXCHANGE, 8'h00, 64'h0);
    push_beat(OP_EXCHANGE, 8'h56, 64'h0);
    push_beat(OP_EXCHANGE, 8'h78, 64'h0);
    push_beat(OP_LOAD, 8'h00, 64'hFFFF_FFFF_FFFF_FF00);
    push_beat(OP_POLL, 8'h00, 64'h0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed();
    wait_drained();

    run_phase(0, 0, 280);

    // The receiver holds off while the sender keeps offering beats, so the
    // block fills its output buffer and stalls its input.
    @(negedge clk);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_phase = 1'b1;
    repeat (5) queue_frame_traffic();
    wait_drained();
    hold_phase = 1'b0;

    run_phase(81, 0, 280);
    run_phase(0, 81, 280);
    run_phase(20, 20, 280);

    repeat (20) @(negedge clk);
    if (mismatches == 0 && slave_replies.size() == 0) begin
      $display("spi_slave_frame_exchange_unit verification clean");
    end else begin
      $display("spi_slave_frame_exchange_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ssfe_pkg.sv
rtl/core/spi_slave_frame_exchange_unit.sv
dv/testbench.sv
